// ===== design/cbt_pkg.sv =====
// Shared types and constants for the counting barrier table.
// No dependencies; every other design file imports this package.
package cbt_pkg;

   // Default table geometry
   localparam int NUM_BARRIERS_DEF = 16;
   localparam int WAITERS_DEF      = 8;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 5;
   localparam int ARRIVE_W = 8;
   localparam int PROC_W   = 8;
   localparam int STATUS_W = 3;
   localparam int RBAR_W   = 4;
   localparam int COUNT_W  = 10;

   // Most negative count; the decrement stops here
   localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REACH   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_CREATED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_WAITS     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_DESTROYED = 3'd6;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_UPDATE,
      ST_REL_ISSUE,
      ST_REL_LOAD
   } state_type;

   // Memory port strobes from the sequencer to the store
   typedef struct packed {
      logic bar_rd;
      logic bar_wr;
      logic wait_rd;
      logic wait_wr;
   } store_ctrl_type;

endpackage

// ===== design/cbt_req_if.sv =====
// Command channel of the counting barrier table: valid/ready plus command fields.
// Depends on cbt_pkg for field widths.
interface cbt_req_if import cbt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [ID_W-1:0]     barrier_id;
   logic [ARRIVE_W-1:0] arrival_count;
   logic [PROC_W-1:0]   proc_id;

   modport source (output valid, cmd, barrier_id, arrival_count, proc_id, input ready);
   modport sink   (input valid, cmd, barrier_id, arrival_count, proc_id, output ready);
endinterface

// ===== design/cbt_rsp_if.sv =====
// Result channel of the counting barrier table: valid/ready plus result fields.
// Depends on cbt_pkg for field widths.
interface cbt_rsp_if import cbt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [RBAR_W-1:0]   result_barrier;
   logic                proc_valid;
   logic [PROC_W-1:0]   released_proc;
   logic                last;

   modport source (output valid, status, result_barrier, proc_valid, released_proc, last,
                   input ready);
   modport sink   (input valid, status, result_barrier, proc_valid, released_proc, last,
                   output ready);
endinterface

// ===== design/cbt_store.sv =====
// Barrier word memory (count and waiter fill) and waiter process memory.
// Depends on cbt_pkg; driven by the sequencer in counting_barrier_table_core.
module cbt_store
   import cbt_pkg::*;
#(
   parameter int NUM_BARRIERS        = NUM_BARRIERS_DEF,
   parameter int WAITERS_PER_BARRIER = WAITERS_DEF,
   localparam int BAR_W  = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1,
   localparam int FILL_W = $clog2(WAITERS_PER_BARRIER + 1),
   localparam int WA_W   = (NUM_BARRIERS * WAITERS_PER_BARRIER > 1) ?
                           $clog2(NUM_BARRIERS * WAITERS_PER_BARRIER) : 1
)(
   input  logic                clock,
   input  store_ctrl_type      ctrl,
   input  logic [BAR_W-1:0]    bar_addr,
   input  logic [COUNT_W-1:0]  bar_wcount,
   input  logic [FILL_W-1:0]   bar_wfill,
   output logic [COUNT_W-1:0]  bar_rcount,
   output logic [FILL_W-1:0]   bar_rfill,
   input  logic [WA_W-1:0]     wait_addr,
   input  logic [PROC_W-1:0]   wait_wdata,
   output logic [PROC_W-1:0]   wait_rdata
);

   localparam int WORD_W = COUNT_W + FILL_W;

   logic [WORD_W-1:0] bar_mem_ff    [NUM_BARRIERS];
   logic [WORD_W-1:0] bar_rd_ff;
   logic [PROC_W-1:0] waiter_mem_ff [NUM_BARRIERS * WAITERS_PER_BARRIER];
   logic [PROC_W-1:0] wait_rd_ff;

   // Barrier word port: one access per cycle, registered read
   always_ff @(posedge clock) begin
      if (ctrl.bar_wr) begin
         bar_mem_ff[bar_addr] <= {bar_wcount, bar_wfill};
      end
      if (ctrl.bar_rd) begin
         bar_rd_ff <= bar_mem_ff[bar_addr];
      end
   end

   // Waiter list port: one access per cycle, registered read
   always_ff @(posedge clock) begin
      if (ctrl.wait_wr) begin
         waiter_mem_ff[wait_addr] <= wait_wdata;
      end
      if (ctrl.wait_rd) begin
         wait_rd_ff <= waiter_mem_ff[wait_addr];
      end
   end

   assign bar_rcount = bar_rd_ff[WORD_W-1 -: COUNT_W];
   assign bar_rfill  = bar_rd_ff[FILL_W-1:0];
   assign wait_rdata = wait_rd_ff;

endmodule

// ===== design/counting_barrier_table_core.sv =====
// Counting barrier table: a small sequencer over the barrier and waiter memories.
// Depends on cbt_pkg, cbt_req_if, cbt_rsp_if and cbt_store.
//
// Usage: commands arrive on req_ch (create, reach, destroy) and results leave
// on rsp_ch, one or more per command; the final result of a command has last
// set. A transfer happens on a clock edge with valid and ready both high.
// The block takes one command at a time: req_ch.ready is high only while the
// sequencer is idle. The sequencer states from the command transfer to its first result:
//   create            DECODE, then SCAN from barrier 0 to the lowest free barrier
//                     (all NUM_BARRIERS barriers are scanned when none is free)
//   bad id            DECODE
//   reach that waits  DECODE, UPDATE, also when the waiter list is full
//   release, destroy  DECODE, UPDATE, REL_ISSUE, and REL_LOAD if there is a waiter,
//                     then REL_ISSUE and REL_LOAD for each further waiter
// The release walk reads one waiter at a time through the single read port of the
// waiter memory, with an issue state and a load state per waiter.
// Results pass through an output register, so the next command is accepted
// while the last result still waits. If rsp_ch.ready stays low the sequencer
// holds at its next result without losing state. Synchronous reset frees all
// barriers at once and drops any pending result; no clearing pass is needed.
module counting_barrier_table_core
   import cbt_pkg::*;
#(
   parameter int NUM_BARRIERS        = NUM_BARRIERS_DEF,
   parameter int WAITERS_PER_BARRIER = WAITERS_DEF
)(
   input  logic      clock,
   input  logic      reset,
   cbt_req_if.sink   req_ch,
   cbt_rsp_if.source rsp_ch
);

   localparam int BAR_W  = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1;
   localparam int SLOT_W = (WAITERS_PER_BARRIER > 1) ? $clog2(WAITERS_PER_BARRIER) : 1;
   localparam int FILL_W = $clog2(WAITERS_PER_BARRIER + 1);
   localparam int WA_W   = (NUM_BARRIERS * WAITERS_PER_BARRIER > 1) ?
                           $clog2(NUM_BARRIERS * WAITERS_PER_BARRIER) : 1;

   // Sequencer and command registers
   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [ARRIVE_W-1:0] arrive_ff;
   logic [PROC_W-1:0]   proc_ff;
   logic [BAR_W-1:0]    scan_ff, scan_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [STATUS_W-1:0] rel_status_ff, rel_status_in;
   logic                live_ff [NUM_BARRIERS];
   logic                live_in [NUM_BARRIERS];

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [RBAR_W-1:0]   rsp_bar_ff, rsp_bar_in;
   logic                rsp_pv_ff, rsp_pv_in;
   logic [PROC_W-1:0]   rsp_proc_ff, rsp_proc_in;
   logic                rsp_last_ff, rsp_last_in;

   // Store interface
   store_ctrl_type      st_ctrl;
   logic [BAR_W-1:0]    bar_addr;
   logic [COUNT_W-1:0]  bar_wcount;
   logic [FILL_W-1:0]   bar_wfill;
   logic [COUNT_W-1:0]  rd_count;
   logic [FILL_W-1:0]   rd_fill;
   logic [WA_W-1:0]     wait_addr;
   logic [PROC_W-1:0]   wait_rdata;
   logic [SLOT_W-1:0]   slot_sel;

   // Shared decode and count unit
   logic                req_accept;
   logic                out_free;
   logic                id_in_range;
   logic [BAR_W-1:0]    id_idx;
   logic                id_hit;
   logic                is_reach;
   logic                is_destroy;
   logic [COUNT_W-1:0]  cnt_new;
   logic                rel_now;
   logic                list_full;
   logic                scan_free;
   logic                scan_end;
   logic                last_waiter;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // Classify the held command against the table
   always_comb begin
      id_in_range = (int'(id_ff) < NUM_BARRIERS);
      id_idx      = BAR_W'(id_ff);
      id_hit      = id_in_range ? live_ff[id_idx] : 1'b0;
      is_reach    = (cmd_ff == CMD_REACH);
      is_destroy  = (cmd_ff == CMD_DESTROY);
      cnt_new     = (rd_count == COUNT_MIN) ? rd_count : rd_count - COUNT_W'(1);
      rel_now     = cnt_new[COUNT_W-1] || (cnt_new == '0);
      list_full   = (rd_fill == FILL_W'(WAITERS_PER_BARRIER));
      scan_free   = !live_ff[scan_ff];
      scan_end    = (scan_ff == BAR_W'(NUM_BARRIERS - 1));
      last_waiter = ((FILL_W'(slot_ff) + FILL_W'(1)) == fill_ff);
   end

   // Address the waiter list: append slot on reach, walk slot on release
   assign slot_sel  = (state_ff == ST_UPDATE) ? SLOT_W'(rd_fill) : slot_ff;
   assign wait_addr = WA_W'(int'(id_idx) * WAITERS_PER_BARRIER + int'(slot_sel));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff)
               CMD_CREATE: state_in = ST_SCAN;
               CMD_REACH, CMD_DESTROY: begin
                  if (id_hit) begin
                     state_in = ST_UPDATE;
                  end else if (out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SCAN: begin
            if ((scan_free || scan_end) && out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            if (is_destroy || rel_now) begin
               state_in = ST_REL_ISSUE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_REL_ISSUE: begin
            if (fill_ff != '0) begin
               state_in = ST_REL_LOAD;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_REL_LOAD: begin
            if (out_free) begin
               state_in = last_waiter ? ST_IDLE : ST_REL_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: memory strobes, table updates and result loads
   always_comb begin
      req_ch.ready  = (state_ff == ST_IDLE);
      st_ctrl       = '0;
      bar_addr      = id_idx;
      bar_wcount    = rd_count;
      bar_wfill     = '0;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      rel_status_in = rel_status_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bar_in    = rsp_bar_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_proc_in   = rsp_proc_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_DECODE: begin
            scan_in        = '0;
            slot_in        = '0;
            st_ctrl.bar_rd = 1'b1;
            if ((is_reach || is_destroy) && !id_hit && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_BAD_ID;
               rsp_bar_in    = id_ff[RBAR_W-1:0];
               rsp_pv_in     = 1'b0;
               rsp_proc_in   = '0;
               rsp_last_in   = 1'b1;
            end
         end
         ST_SCAN: begin
            bar_addr   = scan_ff;
            bar_wcount = COUNT_W'(arrive_ff);
            if (scan_free) begin
               if (out_free) begin
                  st_ctrl.bar_wr   = 1'b1;
                  live_in[scan_ff] = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_CREATED;
                  rsp_bar_in       = RBAR_W'(scan_ff);
                  rsp_pv_in        = 1'b0;
                  rsp_proc_in      = '0;
                  rsp_last_in      = 1'b1;
               end
            end else if (scan_end) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NONE_FREE;
                  rsp_bar_in    = '0;
                  rsp_pv_in     = 1'b0;
                  rsp_proc_in   = '0;
                  rsp_last_in   = 1'b1;
               end
            end else begin
               scan_in = scan_ff + BAR_W'(1);
            end
         end
         ST_UPDATE: begin
            bar_wcount = is_reach ? cnt_new : rd_count;
            fill_in    = rd_fill;
            if (is_destroy || rel_now) begin
               // Empty the list and walk the stored waiters
               st_ctrl.bar_wr = 1'b1;
               bar_wfill      = '0;
               rel_status_in  = is_destroy ? STATUS_DESTROYED : STATUS_RELEASED;
               if (is_destroy) begin
                  live_in[id_idx] = 1'b0;
               end
            end else if (out_free) begin
               st_ctrl.bar_wr = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_bar_in     = id_ff[RBAR_W-1:0];
               rsp_pv_in      = 1'b0;
               rsp_proc_in    = '0;
               rsp_last_in    = 1'b1;
               if (list_full) begin
                  bar_wfill     = rd_fill;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  bar_wfill       = rd_fill + FILL_W'(1);
                  st_ctrl.wait_wr = 1'b1;
                  rsp_status_in   = STATUS_WAITS;
               end
            end
         end
         ST_REL_ISSUE: begin
            if (fill_ff != '0) begin
               st_ctrl.wait_rd = 1'b1;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rel_status_ff;
               rsp_bar_in    = id_ff[RBAR_W-1:0];
               rsp_pv_in     = 1'b0;
               rsp_proc_in   = '0;
               rsp_last_in   = 1'b1;
            end
         end
         ST_REL_LOAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rel_status_ff;
               rsp_bar_in    = id_ff[RBAR_W-1:0];
               rsp_pv_in     = 1'b1;
               rsp_proc_in   = wait_rdata;
               rsp_last_in   = last_waiter;
               if (!last_waiter) begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BARRIERS; b++) begin
            live_ff[b] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_ch.cmd;
         id_ff     <= req_ch.barrier_id;
         arrive_ff <= req_ch.arrival_count;
         proc_ff   <= req_ch.proc_id;
      end
      scan_ff       <= scan_in;
      slot_ff       <= slot_in;
      fill_ff       <= fill_in;
      rel_status_ff <= rel_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bar_ff    <= rsp_bar_in;
      rsp_pv_ff     <= rsp_pv_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_last_ff   <= rsp_last_in;
   end

   cbt_store #(
      .NUM_BARRIERS        (NUM_BARRIERS),
      .WAITERS_PER_BARRIER (WAITERS_PER_BARRIER)
   ) u_store (
      .clock      (clock),
      .ctrl       (st_ctrl),
      .bar_addr   (bar_addr),
      .bar_wcount (bar_wcount),
      .bar_wfill  (bar_wfill),
      .bar_rcount (rd_count),
      .bar_rfill  (rd_fill),
      .wait_addr  (wait_addr),
      .wait_wdata (proc_ff),
      .wait_rdata (wait_rdata)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_barrier = rsp_bar_ff;
   assign rsp_ch.proc_valid     = rsp_pv_ff;
   assign rsp_ch.released_proc  = rsp_proc_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

// ===== design/cbt_chk.sv =====
// Port-level checker for counting_barrier_table_core, attached by bind.
// Depends on cbt_pkg for status codes and field widths.
module cbt_chk
   import cbt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_proc_valid,
   input logic [PROC_W-1:0]   rsp_released_proc,
   input logic                rsp_last
);

   // Hold a stalled result until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Drop ready after a command transfer: one command in flight
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while another is in flight");

   // Carry a process id only on release or destroy results
   a_proc_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_proc_valid |->
         (rsp_status == STATUS_RELEASED) || (rsp_status == STATUS_DESTROYED))
      else $error("released process on a non-release result");

   // Zero the process id when no waiter is released
   a_proc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_proc_valid |-> (rsp_released_proc == '0))
      else $error("process id set without a released waiter");

   // Single-result statuses always close the command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_RELEASED) && (rsp_status != STATUS_DESTROYED)
         |-> rsp_last)
      else $error("single-result status without last");

endmodule

bind counting_barrier_table_core cbt_chk u_cbt_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_proc_valid    (rsp_ch.proc_valid),
   .rsp_released_proc (rsp_ch.released_proc),
   .rsp_last          (rsp_ch.last)
);
